### src/fid_pkg.sv
`default_nettype none

package fid_pkg;

	localparam int MAG_W = 32;
	localparam int TIME_W = 32;
	localparam int WIN_W = 16;
	localparam int CFG_IDX_W = 2;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FALL_THRESH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMPACT_THRESH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FALL_WINDOW = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN = 2'd3;

	localparam logic [MAG_W-1:0] FALL_THRESH_RST = 32'd33554432;
	localparam logic [MAG_W-1:0] IMPACT_THRESH_RST = 32'd1677721600;
	localparam logic [WIN_W-1:0] FALL_WINDOW_RST = 16'd300;
	localparam logic [WIN_W-1:0] COOLDOWN_RST = 16'd2000;

	typedef struct packed {
		logic [MAG_W-1:0] fall_thresh_sq;
		logic [MAG_W-1:0] impact_thresh_sq;
		logic [WIN_W-1:0] fall_window_ms;
		logic [WIN_W-1:0] cooldown_ms;
	} cfg_t;

	typedef struct packed {
		logic fall_event;
		logic impact_event;
		logic [TIME_W-1:0] fall_duration_ms;
		logic [MAG_W-1:0] mag_sq;
		logic [MAG_W-1:0] peak_mag_sq;
		logic [31:0] falls_total;
		logic [31:0] impacts_total;
	} res_t;

endpackage

`default_nettype wire

### src/fid_mag.sv
`default_nettype none

module fid_mag #(
	parameter int SAMPLE_BITS = 16
) (
	input wire logic [SAMPLE_BITS-1:0] x,
	input wire logic [SAMPLE_BITS-1:0] y,
	input wire logic [SAMPLE_BITS-1:0] z,
	output logic [fid_pkg::MAG_W-1:0] mag
);

	localparam int SQ_W = 2 * SAMPLE_BITS;
	// at least one bit above the result so saturation has something to test
	localparam int SUM_W = (SQ_W + 2 > fid_pkg::MAG_W + 1) ? SQ_W + 2 : fid_pkg::MAG_W + 1;

	logic [SAMPLE_BITS-1:0] ax, ay, az;
	logic [SQ_W-1:0] sqx, sqy, sqz;
	logic [SUM_W-1:0] sum;

	// two's complement magnitude; the most negative code maps to 2^(n-1)
	assign ax = x[SAMPLE_BITS-1] ? (~x + 1'b1) : x;
	assign ay = y[SAMPLE_BITS-1] ? (~y + 1'b1) : y;
	assign az = z[SAMPLE_BITS-1] ? (~z + 1'b1) : z;

	assign sqx = ax * ax;
	assign sqy = ay * ay;
	assign sqz = az * az;

	assign sum = SUM_W'(sqx) + SUM_W'(sqy) + SUM_W'(sqz);

	assign mag = (|sum[SUM_W-1:fid_pkg::MAG_W]) ? '1 : sum[fid_pkg::MAG_W-1:0];

endmodule

`default_nettype wire

### src/fid_detect.sv
`default_nettype none

module fid_detect (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step,
	input wire logic [fid_pkg::MAG_W-1:0] mag,
	input wire logic [fid_pkg::TIME_W-1:0] now,
	input wire logic clr,
	input wire fid_pkg::cfg_t cfg,
	output fid_pkg::res_t res
);

	logic in_free_fall_q;
	logic [fid_pkg::TIME_W-1:0] fall_start_q;
	logic [fid_pkg::TIME_W-1:0] last_alert_q;
	logic [fid_pkg::MAG_W-1:0] peak_q;
	logic [31:0] fall_cnt_q;
	logic [31:0] impact_cnt_q;

	logic [fid_pkg::MAG_W-1:0] peak_base, peak_n;
	logic [fid_pkg::TIME_W-1:0] since_alert, start_n, elapsed;
	logic cooling, low, high, start_new, fall, impact;

	assign peak_base = clr ? '0 : peak_q;
	assign peak_n = (mag > peak_base) ? mag : peak_base;

	// differences wrap modulo 2^32
	assign since_alert = now - last_alert_q;
	assign cooling = since_alert < fid_pkg::TIME_W'(cfg.cooldown_ms);

	assign low = mag < cfg.fall_thresh_sq;
	assign high = mag > cfg.impact_thresh_sq;
	assign start_new = low && !in_free_fall_q;
	assign start_n = start_new ? now : fall_start_q;
	assign elapsed = now - start_n;

	assign fall = low && (elapsed >= fid_pkg::TIME_W'(cfg.fall_window_ms)) && !cooling;
	assign impact = high && !cooling;

	always_comb begin
		res.fall_event = fall;
		res.impact_event = impact;
		res.fall_duration_ms = fall ? elapsed : '0;
		res.mag_sq = mag;
		res.peak_mag_sq = peak_n;
		res.falls_total = fall_cnt_q + 32'(fall);
		res.impacts_total = impact_cnt_q + 32'(impact);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_free_fall_q <= 1'b0;
			fall_start_q <= '0;
			last_alert_q <= '0;
			peak_q <= '0;
			fall_cnt_q <= '0;
			impact_cnt_q <= '0;
		end else if (step) begin
			// re-arm after a reported fall
			in_free_fall_q <= low && !fall;
			fall_start_q <= start_n;
			if (fall || impact) begin
				last_alert_q <= now;
			end
			peak_q <= peak_n;
			fall_cnt_q <= res.falls_total;
			impact_cnt_q <= res.impacts_total;
		end
	end

endmodule

`default_nettype wire

### src/fall_impact_detector.sv
`default_nettype none

// channel   signals                                  direction
// sample    sample_valid/ready, accel_*, time_ms,    in
//           clear_peak
// result    result_valid/ready, fall_event, ...      out
// config    cfg_we, cfg_index, cfg_data              in, write only
//
// three register stages: input register, squared magnitude, result register.
// one item per cycle unless results stall; result_valid rises as res_q is loaded.
// detector state (peak, timers, counters) updates as an item enters the
// result register, so each item sees the state left by the one before it.
// reset clears all control state, counters and config to defaults.
// a stalled result backs up the stages behind it; sample_ready drops only when
// all three stages are full.

module fall_impact_detector #(
	parameter int SAMPLE_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,

	input wire logic sample_valid,
	output logic sample_ready,
	input wire logic signed [SAMPLE_BITS-1:0] accel_x,
	input wire logic signed [SAMPLE_BITS-1:0] accel_y,
	input wire logic signed [SAMPLE_BITS-1:0] accel_z,
	input wire logic [fid_pkg::TIME_W-1:0] time_ms,
	input wire logic clear_peak,

	output logic result_valid,
	input wire logic result_ready,
	output logic fall_event,
	output logic impact_event,
	output logic [fid_pkg::TIME_W-1:0] fall_duration_ms,
	output logic [fid_pkg::MAG_W-1:0] mag_sq,
	output logic [fid_pkg::MAG_W-1:0] peak_mag_sq,
	output logic [31:0] falls_total,
	output logic [31:0] impacts_total,

	input wire logic cfg_we,
	input wire logic [fid_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [31:0] cfg_data
);

	fid_pkg::cfg_t cfg_q;

	logic valid_s1, valid_s2, valid_q;
	logic [SAMPLE_BITS-1:0] x_s1, y_s1, z_s1;
	logic [fid_pkg::TIME_W-1:0] time_s1, time_s2;
	logic clr_s1, clr_s2;
	logic [fid_pkg::MAG_W-1:0] mag_c, mag_s2;
	fid_pkg::res_t res_c, res_q;

	logic adv_out, s2_free, adv_s2, s1_free, take;

	assign adv_out = valid_s2 && (!valid_q || result_ready);
	assign s2_free = !valid_s2 || adv_out;
	assign adv_s2 = valid_s1 && s2_free;
	assign s1_free = !valid_s1 || adv_s2;
	assign sample_ready = s1_free;
	assign take = sample_valid && s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fall_thresh_sq <= fid_pkg::FALL_THRESH_RST;
			cfg_q.impact_thresh_sq <= fid_pkg::IMPACT_THRESH_RST;
			cfg_q.fall_window_ms <= fid_pkg::FALL_WINDOW_RST;
			cfg_q.cooldown_ms <= fid_pkg::COOLDOWN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fid_pkg::REG_FALL_THRESH: cfg_q.fall_thresh_sq <= cfg_data;
				fid_pkg::REG_IMPACT_THRESH: cfg_q.impact_thresh_sq <= cfg_data;
				fid_pkg::REG_FALL_WINDOW: cfg_q.fall_window_ms <= cfg_data[fid_pkg::WIN_W-1:0];
				fid_pkg::REG_COOLDOWN: cfg_q.cooldown_ms <= cfg_data[fid_pkg::WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= sample_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (!valid_q || result_ready) begin
				valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_s1 <= accel_x;
			y_s1 <= accel_y;
			z_s1 <= accel_z;
			time_s1 <= time_ms;
			clr_s1 <= clear_peak;
		end
		if (adv_s2) begin
			mag_s2 <= mag_c;
			time_s2 <= time_s1;
			clr_s2 <= clr_s1;
		end
		if (adv_out) begin
			res_q <= res_c;
		end
	end

	fid_mag #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mag (
		.x(x_s1),
		.y(y_s1),
		.z(z_s1),
		.mag(mag_c)
	);

	fid_detect u_detect (
		.clk(clk),
		.arst_n(arst_n),
		.step(adv_out),
		.mag(mag_s2),
		.now(time_s2),
		.clr(clr_s2),
		.cfg(cfg_q),
		.res(res_c)
	);

	assign result_valid = valid_q;
	assign fall_event = res_q.fall_event;
	assign impact_event = res_q.impact_event;
	assign fall_duration_ms = res_q.fall_duration_ms;
	assign mag_sq = res_q.mag_sq;
	assign peak_mag_sq = res_q.peak_mag_sq;
	assign falls_total = res_q.falls_total;
	assign impacts_total = res_q.impacts_total;

	// input side stalls only when every stage holds an item
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> (valid_s1 && valid_s2 && valid_q))
		else $error("sample_ready low with a free stage");

	// a reported peak never falls below the sample that produced it
	a_peak_ge_mag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (peak_mag_sq >= mag_sq))
		else $error("peak below magnitude");

	// duration is only reported with a fall
	a_dur_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !fall_event) |-> (fall_duration_ms == '0))
		else $error("duration without fall");

	// the result register holds the item the detector produced on the advance
	a_state_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv_out |=> (res_q.impacts_total == $past(res_c.impacts_total)))
		else $error("result register lost its item");

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam logic [31:0] MAG_TOP = 32'd3221225472;
	localparam int HOLD_AT = 700;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 4;

	typedef enum {QUIET, REST, HARD, NOISE} motion_t;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [31:0] t;
		logic clr;
	} reading_t;

	typedef struct {
		bit typed;
		fid_pkg::res_t want;
	} row_note_t;

	typedef struct {
		int x;
		int y;
		int z;
		logic [31:0] t;
		bit clr;
		bit typed;
		bit fall;
		bit hit;
		logic [31:0] dur;
		logic [31:0] mag;
		logic [31:0] peak;
		logic [31:0] falls;
		logic [31:0] hits;
	} probe_t;

	// typed rows run from reset with the reset thresholds, the rest come from the predictor
	probe_t probes [20] = '{
		'{0, 0, 0, 32'd0, 0, 1, 0, 0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
		'{-32768, -32768, -32768, 32'd100, 0, 1,
			0, 0, 32'd0, 32'd3221225472, 32'd3221225472, 32'd0, 32'd0},
		'{32767, 0, 0, 32'd200, 1, 1,
			0, 0, 32'd0, 32'd1073676289, 32'd1073676289, 32'd0, 32'd0},
		'{-32768, 0, 0, 32'd2500, 0, 1,
			0, 0, 32'd0, 32'd1073741824, 32'd1073741824, 32'd0, 32'd0},
		'{32767, 32767, 0, 32'd3000, 0, 1,
			0, 1, 32'd0, 32'd2147352578, 32'd2147352578, 32'd0, 32'd1},
		'{32767, 32767, 32767, 32'd3001, 0, 1,
			0, 0, 32'd0, 32'd3221028867, 32'd3221028867, 32'd0, 32'd1},
		'{100, 0, 0, 32'd5001, 0, 1,
			0, 0, 32'd0, 32'd10000, 32'd3221028867, 32'd0, 32'd1},
		'{0, -1, 1, 32'd5300, 0, 1,
			0, 0, 32'd0, 32'd2, 32'd3221028867, 32'd0, 32'd1},
		'{0, 0, 0, 32'd5301, 0, 1,
			1, 0, 32'd300, 32'd0, 32'd3221028867, 32'd1, 32'd1},
		'{0, 0, 50, 32'd5302, 0, 1,
			0, 0, 32'd0, 32'd2500, 32'd3221028867, 32'd1, 32'd1},
		'{6000, 0, 0, 32'd5400, 0, 1,
			0, 0, 32'd0, 32'd36000000, 32'd3221028867, 32'd1, 32'd1},
		'{4096, 4096, 0, 32'd5500, 1, 0, 0, 0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
		'{-32768, 24576, 0, 32'd8000, 0, 0, 0, 0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
		'{-32768, 24577, 0, 32'd8001, 0, 0, 0, 0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
		'{0, 0, 0, 32'hFFFF_FF00, 0, 0, 0, 0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
		'{1, -1, 1, 32'h0000_0010, 0, 0, 0, 0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
		'{0, 0, 0, 32'h0000_0030, 0, 0, 0, 0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
		'{32767, -32768, 32767, 32'h0000_0040, 1, 0,
			0, 0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
		'{-1, -1, -1, 32'h8000_0000, 0, 0, 0, 0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
		'{32767, 32767, 32767, 32'hFFFF_FFFF, 0, 0,
			0, 0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}
	};

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic [31:0] time_ms;
	logic clear_peak;
	logic result_valid;
	logic result_ready;
	logic fall_event;
	logic impact_event;
	logic [31:0] fall_duration_ms;
	logic [31:0] mag_sq;
	logic [31:0] peak_mag_sq;
	logic [31:0] falls_total;
	logic [31:0] impacts_total;
	logic cfg_we;
	logic [fid_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	// detector copy: thresholds and running state
	logic [31:0] lim_fall = fid_pkg::FALL_THRESH_RST;
	logic [31:0] lim_hit = fid_pkg::IMPACT_THRESH_RST;
	logic [15:0] win_ms = fid_pkg::FALL_WINDOW_RST;
	logic [15:0] cool_ms = fid_pkg::COOLDOWN_RST;
	bit low_run = 0;
	logic [31:0] low_since = '0;
	logic [31:0] alert_at = '0;
	logic [31:0] peak = '0;
	logic [31:0] n_falls = '0;
	logic [31:0] n_impacts = '0;

	fid_pkg::res_t pending_reports[$];
	row_note_t row_notes[$];
	int samples_sent = 0;
	int results_seen = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	bit calm = 0;
	logic [31:0] now_ms = '0;

	fall_impact_detector #(
		.SAMPLE_BITS(16)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.accel_x(accel_x),
		.accel_y(accel_y),
		.accel_z(accel_z),
		.time_ms(time_ms),
		.clear_peak(clear_peak),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.fall_event(fall_event),
		.impact_event(impact_event),
		.fall_duration_ms(fall_duration_ms),
		.mag_sq(mag_sq),
		.peak_mag_sq(peak_mag_sq),
		.falls_total(falls_total),
		.impacts_total(impacts_total),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void detect_step(input reading_t rd, output fid_pkg::res_t r);
		longint sx, sy, sz;
		logic [31:0] mag, since_alert, low_for;
		bit cooling;
		sx = rd.x;
		sy = rd.y;
		sz = rd.z;
		mag = 32'(sx * sx + sy * sy + sz * sz);
		r = '0;
		if (rd.clr) peak = '0;
		if (mag > peak) peak = mag;
		since_alert = rd.t - alert_at;
		cooling = since_alert < {16'd0, cool_ms};
		if (mag < lim_fall) begin
			if (!low_run) begin
				low_run = 1;
				low_since = rd.t;
			end
			low_for = rd.t - low_since;
			if (low_for >= {16'd0, win_ms} && !cooling) begin
				r.fall_event = 1'b1;
				r.fall_duration_ms = low_for;
				n_falls++;
				alert_at = rd.t;
				low_run = 0;
			end
		end else begin
			low_run = 0;
		end
		// cooldown was taken before the fall check, so both alerts may fire here
		if (mag > lim_hit && !cooling) begin
			r.impact_event = 1'b1;
			n_impacts++;
			alert_at = rd.t;
		end
		r.mag_sq = mag;
		r.peak_mag_sq = peak;
		r.falls_total = n_falls;
		r.impacts_total = n_impacts;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		reading_t rd;
		fid_pkg::res_t want;
		row_note_t note;
		if (sample_valid && sample_ready) begin
			rd = '{accel_x, accel_y, accel_z, time_ms, clear_peak};
			detect_step(rd, want);
			if (row_notes.size() > 0) begin
				note = row_notes.pop_front();
				if (note.typed) want = note.want;
			end
			pending_reports.push_back(want);
		end
		if (result_valid && result_ready) begin
			results_seen++;
			if (pending_reports.size() == 0) begin
				$error("result with no item waiting");
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				check_field("fall_event", want.fall_event, fall_event);
				check_field("impact_event", want.impact_event, impact_event);
				check_field("fall_duration_ms", want.fall_duration_ms, fall_duration_ms);
				check_field("mag_sq", want.mag_sq, mag_sq);
				check_field("peak_mag_sq", want.peak_mag_sq, peak_mag_sq);
				check_field("falls_total", want.falls_total, falls_total);
				check_field("impacts_total", want.impacts_total, impacts_total);
			end
		end
		if ((sample_valid && sample_ready) || (result_valid && result_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	initial begin
		while (quiet_cycles < STALL_LIMIT) @(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side: random stalls, plus one long hold-off so the pipe backs up
	initial begin
		int gap;
		bit held_off;
		held_off = 0;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_off && samples_sent >= HOLD_AT) begin
				held_off = 1;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = pick_gap();
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	task automatic send_reading(input reading_t rd);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		accel_x <= rd.x;
		accel_y <= rd.y;
		accel_z <= rd.z;
		time_ms <= rd.t;
		clear_peak <= rd.clr;
		do @(posedge clk); while (!sample_ready);
		samples_sent++;
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		while (results_seen != samples_sent) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_config(input logic [31:0] fall_thr, input logic [31:0] hit_thr,
			input logic [31:0] win_word, input logic [31:0] cool_word);
		cfg_we <= 1'b1;
		cfg_index <= fid_pkg::REG_FALL_THRESH;
		cfg_data <= fall_thr;
		@(posedge clk);
		cfg_index <= fid_pkg::REG_IMPACT_THRESH;
		cfg_data <= hit_thr;
		@(posedge clk);
		cfg_index <= fid_pkg::REG_FALL_WINDOW;
		cfg_data <= win_word;
		@(posedge clk);
		cfg_index <= fid_pkg::REG_COOLDOWN;
		cfg_data <= cool_word;
		@(posedge clk);
		cfg_we <= 1'b0;
		lim_fall = fall_thr;
		lim_hit = hit_thr;
		win_ms = win_word[15:0];
		cool_ms = cool_word[15:0];
	endtask

	function automatic logic signed [15:0] axis_for(input motion_t kind, input bit vertical);
		int v;
		case (kind)
			QUIET: v = int'($urandom_range(0, 6000)) - 3000;
			REST: begin
				if (vertical) v = $urandom_range(14000, 18000);
				else v = int'($urandom_range(0, 4000)) - 2000;
			end
			HARD: v = $urandom_range(20000, 32768);
			default: v = $urandom;
		endcase
		if ((kind == HARD || (kind == REST && vertical)) && $urandom_range(0, 1) == 1)
			v = -v;
		if (v == 32768) v = 32767;
		return v[15:0];
	endfunction

	task automatic emit(input motion_t kind, input int unsigned lo, input int unsigned hi);
		reading_t rd;
		now_ms += $urandom_range(lo, hi);
		rd.x = axis_for(kind, 0);
		rd.y = axis_for(kind, 0);
		rd.z = axis_for(kind, 1);
		rd.t = now_ms;
		rd.clr = ($urandom_range(0, 9) == 0);
		send_reading(rd);
	endtask

	task automatic run_phase(input int count);
		int left, burst, pick;
		left = count;
		while (left > 0) begin
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				// drop: a quiet stretch, then the landing
				burst = $urandom_range(3, 30);
				repeat (burst) emit(QUIET, 5, 60);
				emit(HARD, 1, 30);
				left -= burst + 1;
			end else if (pick < 7) begin
				burst = $urandom_range(2, 12);
				repeat (burst) emit(REST, 10, ($urandom_range(0, 7) == 0) ? 70000 : 300);
				left -= burst;
			end else if (pick < 9) begin
				burst = $urandom_range(1, 3);
				repeat (burst) emit(HARD, 1, 500);
				left -= burst;
			end else begin
				burst = $urandom_range(1, 4);
				if ($urandom_range(0, 1) == 1) now_ms = $urandom;
				repeat (burst) emit(NOISE, 0, 100000);
				left -= burst;
			end
		end
	endtask

	initial begin
		reading_t rd;
		row_note_t note;
		int ph;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		accel_x = '0;
		accel_y = '0;
		accel_z = '0;
		time_ms = '0;
		clear_peak = 1'b0;
		cfg_we = 1'b0;
		cfg_index = fid_pkg::REG_FALL_THRESH;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probes[i]) begin
			rd.x = 16'(probes[i].x);
			rd.y = 16'(probes[i].y);
			rd.z = 16'(probes[i].z);
			rd.t = probes[i].t;
			rd.clr = probes[i].clr;
			note.typed = probes[i].typed;
			note.want = '{probes[i].fall, probes[i].hit, probes[i].dur, probes[i].mag,
				probes[i].peak, probes[i].falls, probes[i].hits};
			row_notes.push_back(note);
			send_reading(rd);
		end
		drain();

		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				// upper bits of the 16-bit registers must be dropped
				0: load_config(fid_pkg::FALL_THRESH_RST, fid_pkg::IMPACT_THRESH_RST,
					{16'hA5A5, fid_pkg::FALL_WINDOW_RST},
					{16'h5A5A, fid_pkg::COOLDOWN_RST});
				1: load_config(fid_pkg::FALL_THRESH_RST, fid_pkg::IMPACT_THRESH_RST,
					32'hFFFF_0000, 32'h0);
				// overlapping thresholds: fall and impact together
				2: load_config(MAG_TOP, 32'h0, 32'h0, 32'h0);
				3: load_config(32'h0, MAG_TOP, 32'h0000_FFFF, 32'hFFFF_FFFF);
				6: load_config(fid_pkg::FALL_THRESH_RST, fid_pkg::IMPACT_THRESH_RST,
					32'h0000_FFFF, 32'd1);
				default: load_config($urandom_range(1000000, 300000000),
					$urandom_range(400000000, MAG_TOP),
					$urandom_range(0, 1500), $urandom_range(0, 4000));
			endcase
			if ($urandom_range(0, 2) == 0) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
			calm = (ph == 4) || ($urandom_range(0, 3) == 0);
			run_phase(180);
			drain();
		end

		repeat (10) @(posedge clk);
		if (pending_reports.size() != 0) begin
			$error("%0d results never arrived", pending_reports.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
